// ===== hw/rtl/sttbl_pkg.sv =====
// ----------------------------------------------------------------------------
// Software timer table package
// Shared widths, field codes, command and report types.
// ----------------------------------------------------------------------------
package sttbl_pkg;

    localparam int KIND_W    = 2;
    localparam int ID_W      = 16;
    localparam int PERIOD_W  = 24;
    localparam int ELAPSED_W = 16;
    localparam int RPT_W     = 2;

    // Depth of the command queue between the front and back ends.
    localparam int QUEUE_DEPTH = 2;

    // Input item kinds.
    localparam logic [KIND_W-1:0] KIND_ADD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_KILL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

    // Report kinds.
    localparam logic [RPT_W-1:0] RPT_ADD   = 2'd0;
    localparam logic [RPT_W-1:0] RPT_KILL  = 2'd1;
    localparam logic [RPT_W-1:0] RPT_FIRED = 2'd2;
    localparam logic [RPT_W-1:0] RPT_QUIET = 2'd3;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_KILL = 2'd1,
        OP_TICK = 2'd2
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [PERIOD_W-1:0]  period;
        logic                 rpt;
        logic [ID_W-1:0]      id;
        logic [ELAPSED_W-1:0] elapsed;
    } t_cmd;

    typedef struct packed {
        logic [RPT_W-1:0] kind;
        logic [ID_W-1:0]  number;
        logic             ok;
        logic             last;
    } t_report;

endpackage

// ===== hw/rtl/sttbl_if.sv =====
// ----------------------------------------------------------------------------
// Software timer table channel interfaces
// Item channel into the table and report channel out of it.
// ----------------------------------------------------------------------------
interface sttbl_item_if;
    logic                            valid;
    logic                            ready;
    logic [sttbl_pkg::KIND_W-1:0]    kind;
    logic [sttbl_pkg::PERIOD_W-1:0]  period_ticks;
    logic                            repeat_req;
    logic [sttbl_pkg::ID_W-1:0]      target_id;
    logic [sttbl_pkg::ELAPSED_W-1:0] elapsed_ticks;

    modport source (
        output valid, kind, period_ticks, repeat_req, target_id, elapsed_ticks,
        input  ready
    );
    modport sink (
        input  valid, kind, period_ticks, repeat_req, target_id, elapsed_ticks,
        output ready
    );
endinterface

interface sttbl_report_if;
    logic                         valid;
    logic                         ready;
    logic [sttbl_pkg::RPT_W-1:0]  report_kind;
    logic [sttbl_pkg::ID_W-1:0]   timer_number;
    logic                         ok;
    logic                         last;

    modport source (
        output valid, report_kind, timer_number, ok, last,
        input  ready
    );
    modport sink (
        input  valid, report_kind, timer_number, ok, last,
        output ready
    );
endinterface

// ===== hw/rtl/software_timer_table.sv =====
// ----------------------------------------------------------------------------
// Software timer table
// Ordered table of countdown timers with add, kill and tick commands.
// ----------------------------------------------------------------------------
//  Channel    Direction  Payload                                        Reports
//  i_item     in         kind, period_ticks, repeat_req, target_id,     -
//                        elapsed_ticks
//  o_report   out        report_kind, timer_number, ok, last            0 to SLOTS
//
//  The back end does an add or a quiet tick in its idle state, a kill in its kill
//  state and a firing tick by a walk of the table, one entry a cycle unless a
//  firing report waits on the receiver. Reset is synchronous and empties the
//  table and zeroes the id counter. A front register and a two-entry queue keep
//  items flowing in while the report register waits on a stalled receiver.
// ----------------------------------------------------------------------------
module software_timer_table #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 24
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sttbl_item_if.sink      i_item,
    sttbl_report_if.source  o_report
);

    logic            front_vld;
    logic            front_rdy;
    sttbl_pkg::t_cmd front_cmd;
    logic            queue_vld;
    logic            queue_pop;
    sttbl_pkg::t_cmd queue_cmd;

    sttbl_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .o_cmd_vld (front_vld),
        .i_cmd_rdy (front_rdy),
        .o_cmd     (front_cmd)
    );

    sttbl_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_vld (front_vld),
        .o_push_rdy (front_rdy),
        .i_push_cmd (front_cmd),
        .o_pop_vld  (queue_vld),
        .i_pop      (queue_pop),
        .o_pop_cmd  (queue_cmd)
    );

    sttbl_back #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (queue_vld),
        .o_cmd_pop (queue_pop),
        .i_cmd     (queue_cmd),
        .o_report  (o_report)
    );

endmodule

// ===== hw/rtl/sttbl_front.sv =====
// ----------------------------------------------------------------------------
// Software timer table front end
// Accepts input items, decodes the kind and registers a command for the queue.
// ----------------------------------------------------------------------------
module sttbl_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sttbl_item_if.sink        i_item,
    output logic              o_cmd_vld,
    input  logic              i_cmd_rdy,
    output sttbl_pkg::t_cmd   o_cmd
);

    logic            r_vld;
    logic            n_vld;
    sttbl_pkg::t_cmd r_cmd;
    sttbl_pkg::t_cmd n_cmd;
    logic            accept;
    logic            known;

    assign i_item.ready = !r_vld || i_cmd_rdy;
    assign accept       = i_item.valid && i_item.ready;

    always_comb begin
        known          = 1'b1;
        n_cmd          = r_cmd;
        n_cmd.period   = i_item.period_ticks;
        n_cmd.rpt      = i_item.repeat_req;
        n_cmd.id       = i_item.target_id;
        n_cmd.elapsed  = i_item.elapsed_ticks;
        case (i_item.kind)
            sttbl_pkg::KIND_ADD:  n_cmd.op = sttbl_pkg::OP_ADD;
            sttbl_pkg::KIND_KILL: n_cmd.op = sttbl_pkg::OP_KILL;
            sttbl_pkg::KIND_TICK: n_cmd.op = sttbl_pkg::OP_TICK;
            default: begin
                // An unused kind is dropped here and never reaches the table.
                known = 1'b0;
            end
        endcase
        n_vld = (r_vld && !i_cmd_rdy) || (accept && known);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_vld = r_vld;
    assign o_cmd     = r_cmd;

endmodule

// ===== hw/rtl/sttbl_queue.sv =====
// ----------------------------------------------------------------------------
// Software timer table command queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module sttbl_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_vld,
    output logic              o_push_rdy,
    input  sttbl_pkg::t_cmd   i_push_cmd,
    output logic              o_pop_vld,
    input  logic              i_pop,
    output sttbl_pkg::t_cmd   o_pop_cmd
);

    localparam int DEPTH = sttbl_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sttbl_pkg::t_cmd  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_fill;
    logic             push;
    logic             pop;

    assign o_push_rdy = (r_fill != CNT_W'(DEPTH));
    assign o_pop_vld  = (r_fill != '0);
    assign push       = i_push_vld && o_push_rdy;
    assign pop        = i_pop && o_pop_vld;
    assign o_pop_cmd  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ===== hw/rtl/sttbl_back.sv =====
// ----------------------------------------------------------------------------
// Software timer table back end
// Holds the packed timer table and carries out add, kill and tick commands.
// ----------------------------------------------------------------------------
module sttbl_back #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_vld,
    output logic              o_cmd_pop,
    input  sttbl_pkg::t_cmd   i_cmd,
    sttbl_report_if.source    o_report
);

    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CMP_W = (TIME_BITS > sttbl_pkg::ELAPSED_W) ? TIME_BITS
                                                               : sttbl_pkg::ELAPSED_W;
    localparam int PER_W = (TIME_BITS > sttbl_pkg::PERIOD_W) ? TIME_BITS
                                                              : sttbl_pkg::PERIOD_W;

    typedef struct packed {
        logic [sttbl_pkg::ID_W-1:0] id;
        logic [TIME_BITS-1:0]       remain;
        logic [TIME_BITS-1:0]       period;
        logic                       rpt;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_KILL = 3'b010,
        ST_WALK = 3'b100
    } t_state;

    t_state                     r_state, n_state;
    t_entry                     r_tab [SLOTS];
    t_entry                     n_tab [SLOTS];
    t_entry                     up    [SLOTS];
    logic [CNT_W-1:0]           r_count, n_count;
    logic [CNT_W-1:0]           r_steps, n_steps;
    logic [sttbl_pkg::ID_W-1:0] r_next_id, n_next_id;
    logic [sttbl_pkg::ID_W-1:0] r_target, n_target;
    logic [SLOTS-1:0]           r_flags, n_flags;
    logic                       r_out_vld, n_out_vld;
    sttbl_pkg::t_report         r_out, n_out;
    logic                       out_free;

    assign out_free = !r_out_vld || o_report.ready;

    // Each slot seen from the one above it, for closing gaps in the table.
    always_comb begin
        for (int j = 0; j < SLOTS; j++) begin
            up[j] = r_tab[(j + 1) % SLOTS];
        end
    end

    always_comb begin
        logic [SLOTS-1:0] below;
        logic [PER_W-1:0] per_ext;
        logic [CMP_W-1:0] el_ext;
        logic [CMP_W-1:0] rem_ext;
        t_entry           proc;
        logic             keep;

        n_state   = r_state;
        n_tab     = r_tab;
        n_count   = r_count;
        n_steps   = r_steps;
        n_next_id = r_next_id;
        n_target  = r_target;
        n_flags   = r_flags;
        n_out_vld = r_out_vld && !o_report.ready;
        n_out     = r_out;
        o_cmd_pop = 1'b0;
        below     = '0;
        per_ext   = PER_W'(i_cmd.period);
        el_ext    = CMP_W'(i_cmd.elapsed);
        rem_ext   = '0;
        proc      = r_tab[0];
        keep      = 1'b1;

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_vld) begin
                    case (i_cmd.op)
                        sttbl_pkg::OP_ADD: begin
                            if (out_free) begin
                                o_cmd_pop      = 1'b1;
                                n_out_vld      = 1'b1;
                                n_out.kind     = sttbl_pkg::RPT_ADD;
                                n_out.last     = 1'b1;
                                if (r_count == CNT_W'(SLOTS)) begin
                                    n_out.number = '0;
                                    n_out.ok     = 1'b0;
                                end else begin
                                    for (int j = 0; j < SLOTS; j++) begin
                                        if (r_count == CNT_W'(j)) begin
                                            n_tab[j].id     = r_next_id;
                                            n_tab[j].period = per_ext[TIME_BITS-1:0];
                                            n_tab[j].remain = per_ext[TIME_BITS-1:0];
                                            n_tab[j].rpt    = i_cmd.rpt;
                                        end
                                    end
                                    n_count      = r_count + 1'b1;
                                    n_next_id    = r_next_id + 1'b1;
                                    n_out.number = r_next_id;
                                    n_out.ok     = 1'b1;
                                end
                            end
                        end
                        sttbl_pkg::OP_KILL: begin
                            o_cmd_pop = 1'b1;
                            n_target  = i_cmd.id;
                            for (int j = 0; j < SLOTS; j++) begin
                                n_flags[j] = (r_count > CNT_W'(j)) &&
                                             (r_tab[j].id == i_cmd.id);
                            end
                            n_state = ST_KILL;
                        end
                        sttbl_pkg::OP_TICK: begin
                            if (out_free) begin
                                o_cmd_pop = 1'b1;
                                n_flags   = '0;
                                // Timers that survive count down here in parallel;
                                // those that fire are handled by the walk.
                                for (int j = 0; j < SLOTS; j++) begin
                                    rem_ext = CMP_W'(r_tab[j].remain);
                                    if (r_count > CNT_W'(j)) begin
                                        if (el_ext > rem_ext) begin
                                            n_flags[j] = 1'b1;
                                        end else begin
                                            n_tab[j].remain = TIME_BITS'(rem_ext - el_ext);
                                        end
                                    end
                                end
                                if (n_flags == '0) begin
                                    n_out_vld    = 1'b1;
                                    n_out.kind   = sttbl_pkg::RPT_QUIET;
                                    n_out.number = '0;
                                    n_out.ok     = 1'b1;
                                    n_out.last   = 1'b1;
                                end else begin
                                    n_steps = r_count;
                                    n_state = ST_WALK;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_KILL: begin
                if (out_free) begin
                    // Slots below the oldest match stay; the rest move down one.
                    below = ~r_flags & (r_flags - SLOTS'(1));
                    if (r_flags != '0) begin
                        for (int j = 0; j < SLOTS; j++) begin
                            if (!below[j]) begin
                                n_tab[j] = up[j];
                            end
                        end
                        n_count = r_count - 1'b1;
                    end
                    n_out_vld    = 1'b1;
                    n_out.kind   = sttbl_pkg::RPT_KILL;
                    n_out.number = r_target;
                    n_out.ok     = (r_flags != '0);
                    n_out.last   = 1'b1;
                    n_state      = ST_IDLE;
                end
            end

            ST_WALK: begin
                // The head timer is taken off, and put back at the tail unless it
                // was a one-shot that fired, so order is kept after a full pass.
                if (!(r_flags[0] && !out_free)) begin
                    if (r_flags[0]) begin
                        n_out_vld    = 1'b1;
                        n_out.kind   = sttbl_pkg::RPT_FIRED;
                        n_out.number = r_tab[0].id;
                        n_out.ok     = 1'b1;
                        n_out.last   = ((r_flags >> 1) == '0);
                        if (r_tab[0].rpt) begin
                            proc.remain = r_tab[0].period;
                        end else begin
                            keep = 1'b0;
                        end
                    end
                    for (int j = 0; j < SLOTS; j++) begin
                        n_tab[j] = up[j];
                        if (keep && (r_count == CNT_W'(j + 1))) begin
                            n_tab[j] = proc;
                        end
                    end
                    if (!keep) begin
                        n_count = r_count - 1'b1;
                    end
                    n_flags = r_flags >> 1;
                    n_steps = r_steps - 1'b1;
                    if (r_steps == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_steps   <= '0;
            r_next_id <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_steps   <= n_steps;
            r_next_id <= n_next_id;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tab    <= n_tab;
        r_target <= n_target;
        r_flags  <= n_flags;
        r_out    <= n_out;
    end

    assign o_report.valid        = r_out_vld;
    assign o_report.report_kind  = r_out.kind;
    assign o_report.timer_number = r_out.number;
    assign o_report.ok           = r_out.ok;
    assign o_report.last         = r_out.last;

endmodule
